[hdl/lockable_register_file_defines.svh]
// Assertion macros for the lockable register file.
`ifndef LOCKABLE_REGISTER_FILE_DEFINES_SVH
`define LOCKABLE_REGISTER_FILE_DEFINES_SVH

`ifndef SYNTH

`define LRF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lockable register file: implication check failed");

`define LRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lockable register file: next cycle check failed");

`else

`define LRF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LRF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hdl/lrf_pkg.sv]
package lrf_pkg;

   typedef enum logic [2:0] {
      ACT_READ      = 3'd0,
      ACT_WRITE     = 3'd1,
      ACT_INCREMENT = 3'd2,
      ACT_RAW_WRITE = 3'd3,
      ACT_GET_FLAG  = 3'd4,
      ACT_CLR_FLAG  = 3'd5,
      ACT_SET_CLASS = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      STAT_DONE   = 2'd0,
      STAT_RANGE  = 2'd1,
      STAT_LOCKED = 2'd2
   } status_type;

   localparam logic [1:0] CLASS_OPEN = 2'd0;
   localparam logic [1:0] CLASS_USER = 2'd1;

   localparam logic CSR_USER_KEY   = 1'b0;
   localparam logic CSR_MASTER_KEY = 1'b1;

   typedef struct packed {
      logic [1:0] acc_class;
      logic       changed;
      logic [7:0] value;
   } entry_type;

   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      entry_type  data;
   } wr_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] reg_index;
      logic [7:0] write_data;
      logic [1:0] access_class;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       changed_flag;
      logic [1:0] status;
   } rsp_type;

endpackage

[hdl/lockable_register_file.sv]
// Lockable register file: byte entries, each with an access class and a changed flag.
//
// Commands enter on req_*: a word is taken at a rising edge with start high and
// busy low. busy stays low, so a new word may be issued in every cycle.
// Each word yields exactly one result on rsp_*, marked by rsp_strobe for one
// cycle. A word passes the command register and the store read, then the result
// register; throughput is 1 word per cycle, set by the single
// write port of the entry store (one entry or one counter updated per word).
// Lock entries and counter entries are mirrored in flip-flops so the key
// compare and the counter bump never need a second store read.
// Keys are written on csr_* (index 0 user key, index 1 master key); the user must write
// them only while idle, which the block does not enforce. Reset clears keys, pipeline
// and per-entry valid bits; an entry never written reads as zero, so no clearing pass
// is needed. The receiver cannot stall: results must be taken in their strobe cycle.
`include "lockable_register_file_defines.svh"

module lockable_register_file #(
   parameter int TABLE_DEPTH        = 128,
   parameter int USER_LOCK_INDEX    = 120,
   parameter int MASTER_LOCK_INDEX  = 121,
   parameter int RANGE_COUNT_INDEX  = 122,
   parameter int LOCKED_COUNT_INDEX = 123
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_action,
   input  logic [7:0] req_reg_index,
   input  logic [7:0] req_write_data,
   input  logic [1:0] req_access_class,
   output logic       rsp_strobe,
   output logic [7:0] rsp_read_data,
   output logic       rsp_changed_flag,
   output logic [1:0] rsp_status,
   input  logic       csr_wen,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);
   import lrf_pkg::*;

   localparam logic [7:0] USER_ADDR   = 8'(USER_LOCK_INDEX);
   localparam logic [7:0] MASTER_ADDR = 8'(MASTER_LOCK_INDEX);
   localparam logic [7:0] RANGE_ADDR  = 8'(RANGE_COUNT_INDEX);
   localparam logic [7:0] LOCKED_ADDR = 8'(LOCKED_COUNT_INDEX);

   logic       accept;
   logic [7:0] user_key_ff;
   logic [7:0] master_key_ff;
   logic       stg_valid_ff;
   req_type    stg_ff;
   req_type    stg_in;
   entry_type  cur;
   entry_type  sh_user_ff;
   entry_type  sh_master_ff;
   entry_type  sh_range_ff;
   entry_type  sh_locked_ff;
   wr_type     wr;
   rsp_type    rsp_in;
   rsp_type    rsp_ff;
   logic       rsp_strobe_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign stg_in.action       = req_action;
   assign stg_in.reg_index    = req_reg_index;
   assign stg_in.write_data   = req_write_data;
   assign stg_in.access_class = req_access_class;

   always_ff @(posedge clock) begin
      if (reset) begin
         user_key_ff   <= '0;
         master_key_ff <= '0;
      end else if (csr_wen) begin
         if (csr_index == CSR_USER_KEY) begin
            user_key_ff <= csr_wdata;
         end
         if (csr_index == CSR_MASTER_KEY) begin
            master_key_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         stg_valid_ff  <= accept;
         rsp_strobe_ff <= stg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_ff <= stg_in;
      end
      if (stg_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   // mirror the fixed lock and counter entries
   always_ff @(posedge clock) begin
      if (reset) begin
         sh_user_ff   <= '0;
         sh_master_ff <= '0;
         sh_range_ff  <= '0;
         sh_locked_ff <= '0;
      end else if (wr.en) begin
         if (wr.addr == USER_ADDR) begin
            sh_user_ff <= wr.data;
         end
         if (wr.addr == MASTER_ADDR) begin
            sh_master_ff <= wr.data;
         end
         if (wr.addr == RANGE_ADDR) begin
            sh_range_ff <= wr.data;
         end
         if (wr.addr == LOCKED_ADDR) begin
            sh_locked_ff <= wr.data;
         end
      end
   end

   lrf_store #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (req_reg_index),
      .wr       (wr),
      .rd_entry (cur)
   );

   lrf_exec #(
      .TABLE_DEPTH        (TABLE_DEPTH),
      .RANGE_COUNT_INDEX  (RANGE_COUNT_INDEX),
      .LOCKED_COUNT_INDEX (LOCKED_COUNT_INDEX)
   ) u_exec (
      .valid      (stg_valid_ff),
      .req        (stg_ff),
      .cur        (cur),
      .sh_user    (sh_user_ff),
      .sh_master  (sh_master_ff),
      .sh_range   (sh_range_ff),
      .sh_locked  (sh_locked_ff),
      .user_key   (user_key_ff),
      .master_key (master_key_ff),
      .wr         (wr),
      .rsp        (rsp_in)
   );

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_read_data    = rsp_ff.read_data;
   assign rsp_changed_flag = rsp_ff.changed_flag;
   assign rsp_status       = rsp_ff.status;

   `LRF_ASSERT_NEXT(a_rsp_follows_accept, clock, reset, accept, ##1 rsp_strobe)
   `LRF_ASSERT_IMPLY(a_rsp_has_cause, clock, reset, rsp_strobe, $past(accept, 2))
   `LRF_ASSERT_IMPLY(a_locked_only_on_change, clock, reset, rsp_strobe && rsp_status == STAT_LOCKED, $past(req_action, 2) == ACT_WRITE || $past(req_action, 2) == ACT_INCREMENT)
   `LRF_ASSERT_IMPLY(a_fail_has_no_data, clock, reset, rsp_strobe && rsp_status != STAT_DONE, rsp_read_data == 8'd0 && !rsp_changed_flag)

endmodule

[hdl/lrf_store.sv]
module lrf_store #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [7:0]         rd_addr,
   input  lrf_pkg::wr_type    wr,
   output lrf_pkg::entry_type rd_entry
);
   import lrf_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   entry_type              mem_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   entry_type              rdata_ff;
   logic                   hit_ff;
   logic                   fwd_ff;
   entry_type              fwd_data_ff;
   logic                   rd_ok;
   logic [IDX_W-1:0]       raddr;
   logic [IDX_W-1:0]       waddr;

   assign rd_ok = {1'b0, rd_addr} < 9'(TABLE_DEPTH);
   assign raddr = rd_addr[IDX_W-1:0];
   assign waddr = wr.addr[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[waddr] <= wr.data;
      end
      if (rd_en && rd_ok) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   // bypass a write landing on the same edge as the read
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         hit_ff <= rd_ok && valid_ff[raddr];
         fwd_ff <= wr.en && (wr.addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_data_ff <= wr.data;
      end
   end

   assign rd_entry = fwd_ff ? fwd_data_ff : (hit_ff ? rdata_ff : '0);

endmodule

[hdl/lrf_exec.sv]
module lrf_exec #(
   parameter int TABLE_DEPTH        = 128,
   parameter int RANGE_COUNT_INDEX  = 122,
   parameter int LOCKED_COUNT_INDEX = 123
) (
   input  logic               valid,
   input  lrf_pkg::req_type   req,
   input  lrf_pkg::entry_type cur,
   input  lrf_pkg::entry_type sh_user,
   input  lrf_pkg::entry_type sh_master,
   input  lrf_pkg::entry_type sh_range,
   input  lrf_pkg::entry_type sh_locked,
   input  logic [7:0]         user_key,
   input  logic [7:0]         master_key,
   output lrf_pkg::wr_type    wr,
   output lrf_pkg::rsp_type   rsp
);
   import lrf_pkg::*;

   localparam logic [7:0] RANGE_ADDR  = 8'(RANGE_COUNT_INDEX);
   localparam logic [7:0] LOCKED_ADDR = 8'(LOCKED_COUNT_INDEX);
   localparam logic RANGE_OK  = RANGE_COUNT_INDEX < TABLE_DEPTH;
   localparam logic LOCKED_OK = LOCKED_COUNT_INDEX < TABLE_DEPTH;

   logic      in_range;
   logic      user_in;
   logic      master_in;
   logic      allowed;
   entry_type nxt;
   entry_type range_bump;
   entry_type locked_bump;

   assign in_range  = {1'b0, req.reg_index} < 9'(TABLE_DEPTH);
   assign user_in   = sh_user.value == user_key;
   assign master_in = sh_master.value == master_key;

   always_comb begin
      case (cur.acc_class)
         CLASS_OPEN: allowed = 1'b1;
         CLASS_USER: allowed = user_in || master_in;
         default:    allowed = master_in;
      endcase
   end

   always_comb begin
      range_bump         = sh_range;
      range_bump.value   = sh_range.value + 8'd1;
      range_bump.changed = 1'b1;
      locked_bump         = sh_locked;
      locked_bump.value   = sh_locked.value + 8'd1;
      locked_bump.changed = 1'b1;
   end

   always_comb begin
      nxt     = cur;
      wr      = '0;
      wr.addr = req.reg_index;
      rsp     = '0;
      if (valid && (req.action inside {[ACT_READ:ACT_SET_CLASS]})) begin
         if (!in_range) begin
            wr.en      = RANGE_OK;
            wr.addr    = RANGE_ADDR;
            nxt        = range_bump;
            rsp.status = STAT_RANGE;
         end else begin
            case (action_type'(req.action))
               ACT_READ: begin
                  rsp.read_data = cur.value;
               end
               ACT_WRITE, ACT_INCREMENT: begin
                  if (allowed) begin
                     wr.en       = 1'b1;
                     nxt.changed = 1'b1;
                     nxt.value   = (req.action == ACT_WRITE) ? req.write_data
                                                             : cur.value + 8'd1;
                  end else begin
                     wr.en      = LOCKED_OK;
                     wr.addr    = LOCKED_ADDR;
                     nxt        = locked_bump;
                     rsp.status = STAT_LOCKED;
                  end
               end
               ACT_RAW_WRITE: begin
                  wr.en     = 1'b1;
                  nxt.value = req.write_data;
               end
               ACT_GET_FLAG: begin
                  rsp.changed_flag = cur.changed;
               end
               ACT_CLR_FLAG: begin
                  wr.en       = 1'b1;
                  nxt.changed = 1'b0;
               end
               ACT_SET_CLASS: begin
                  wr.en         = 1'b1;
                  nxt.acc_class = req.access_class;
               end
               default: begin
               end
            endcase
         end
      end
      wr.data = nxt;
   end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import lrf_pkg::*;

   localparam int TABLE_DEPTH        = 128;
   localparam int USER_LOCK_INDEX    = 120;
   localparam int MASTER_LOCK_INDEX  = 121;
   localparam int RANGE_COUNT_INDEX  = 122;
   localparam int LOCKED_COUNT_INDEX = 123;

   localparam logic [2:0] ACT_UNUSED   = 3'd7;
   localparam logic [1:0] CLASS_MASTER = 2'd2;
   localparam logic [1:0] CLASS_SPARE  = 2'd3;

   localparam int WORDS_PER_PHASE = 290;
   localparam int PHASE_COUNT     = 6;
   localparam int DRAIN_CYCLES    = 4;
   localparam int CYCLE_LIMIT     = 100000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [2:0] req_action = '0;
   logic [7:0] req_reg_index = '0;
   logic [7:0] req_write_data = '0;
   logic [1:0] req_access_class = '0;
   logic       rsp_strobe;
   logic [7:0] rsp_read_data;
   logic       rsp_changed_flag;
   logic [1:0] rsp_status;
   logic       csr_wen = 1'b0;
   logic       csr_index = 1'b0;
   logic [7:0] csr_wdata = '0;

   logic [7:0] entry_value [TABLE_DEPTH];
   logic [1:0] entry_class [TABLE_DEPTH];
   logic       entry_changed [TABLE_DEPTH];
   logic [7:0] user_key = '0;
   logic [7:0] master_key = '0;

   req_type pending_words [$];
   rsp_type expected_results [$];

   int idle_pct = 0;
   int cycle_count = 0;
   int error_count = 0;
   int words_sent = 0;
   int results_checked = 0;
   int refused_count = 0;
   int range_count = 0;

   lockable_register_file #(
      .TABLE_DEPTH       (TABLE_DEPTH),
      .USER_LOCK_INDEX   (USER_LOCK_INDEX),
      .MASTER_LOCK_INDEX (MASTER_LOCK_INDEX),
      .RANGE_COUNT_INDEX (RANGE_COUNT_INDEX),
      .LOCKED_COUNT_INDEX(LOCKED_COUNT_INDEX)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_reg_index   (req_reg_index),
      .req_write_data  (req_write_data),
      .req_access_class(req_access_class),
      .rsp_strobe      (rsp_strobe),
      .rsp_read_data   (rsp_read_data),
      .rsp_changed_flag(rsp_changed_flag),
      .rsp_status      (rsp_status),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic req_type make_word(logic [2:0] act, logic [7:0] idx,
                                         logic [7:0] data, logic [1:0] cls);
      req_type w;
      w.action = act;
      w.reg_index = idx;
      w.write_data = data;
      w.access_class = cls;
      return w;
   endfunction

   function automatic logic change_permitted(logic [7:0] idx);
      logic master_in;
      logic user_in;
      master_in = (entry_value[MASTER_LOCK_INDEX] == master_key);
      user_in = (entry_value[USER_LOCK_INDEX] == user_key);
      if (entry_class[idx] == CLASS_OPEN)
         return 1'b1;
      if (entry_class[idx] == CLASS_USER)
         return user_in || master_in;
      return master_in;
   endfunction

   task automatic bump_counter(int idx);
      if (idx < TABLE_DEPTH) begin
         entry_value[idx] = entry_value[idx] + 8'd1;
         entry_changed[idx] = 1'b1;
      end
   endtask

   task automatic apply_command(input req_type w, output rsp_type r);
      int idx;
      idx = int'(w.reg_index);
      r = '0;
      if (w.action == ACT_UNUSED) begin
         r = '0;
      end else if (idx >= TABLE_DEPTH) begin
         bump_counter(RANGE_COUNT_INDEX);
         r.status = STAT_RANGE;
      end else begin
         case (w.action)
            ACT_READ: begin
               r.read_data = entry_value[idx];
            end
            ACT_WRITE, ACT_INCREMENT: begin
               if (change_permitted(w.reg_index)) begin
                  if (w.action == ACT_WRITE)
                     entry_value[idx] = w.write_data;
                  else
                     entry_value[idx] = entry_value[idx] + 8'd1;
                  entry_changed[idx] = 1'b1;
               end else begin
                  bump_counter(LOCKED_COUNT_INDEX);
                  r.status = STAT_LOCKED;
               end
            end
            ACT_RAW_WRITE: begin
               entry_value[idx] = w.write_data;
            end
            ACT_GET_FLAG: begin
               r.changed_flag = entry_changed[idx];
            end
            ACT_CLR_FLAG: begin
               entry_changed[idx] = 1'b0;
            end
            default: begin
               entry_class[idx] = w.access_class;
            end
         endcase
      end
   endtask

   function automatic req_type random_word();
      int pick;
      logic [2:0] act;
      logic [7:0] idx;
      logic [7:0] data;
      pick = int'($urandom_range(99));
      if (pick < 12)
         idx = 8'($urandom_range(255, TABLE_DEPTH));
      else if (pick < 27)
         idx = $urandom_range(1) ? 8'(USER_LOCK_INDEX) : 8'(MASTER_LOCK_INDEX);
      else if (pick < 33)
         idx = $urandom_range(1) ? 8'(RANGE_COUNT_INDEX) : 8'(LOCKED_COUNT_INDEX);
      else if (pick < 85)
         idx = 8'($urandom_range(15, 0));
      else
         idx = 8'($urandom_range(TABLE_DEPTH - 1, 0));
      act = ($urandom_range(99) < 3) ? ACT_UNUSED : 3'($urandom_range(6, 0));
      pick = int'($urandom_range(99));
      if (pick < 18)
         data = user_key;
      else if (pick < 36)
         data = master_key;
      else
         data = 8'($urandom_range(255, 0));
      return make_word(act, idx, data, 2'($urandom_range(3, 0)));
   endfunction

   task automatic write_key(input logic which, input logic [7:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      if (which == CSR_USER_KEY)
         user_key = value;
      else
         master_key = value;
   endtask

   task automatic wait_idle();
      while (pending_words.size() != 0 || expected_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // driver: present the oldest pending word unless idling
   always @(negedge clock) begin
      if (reset || pending_words.size() == 0 || $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
      end else begin
         start <= 1'b1;
         req_action <= pending_words[0].action;
         req_reg_index <= pending_words[0].reg_index;
         req_write_data <= pending_words[0].write_data;
         req_access_class <= pending_words[0].access_class;
      end
   end

   // accept words and predict their results
   always @(posedge clock) begin
      req_type w;
      rsp_type r;
      if (!reset && start && !busy) begin
         w = make_word(req_action, req_reg_index, req_write_data, req_access_class);
         apply_command(w, r);
         expected_results.push_back(r);
         if (pending_words.size() != 0)
            pending_words.pop_front();
         words_sent++;
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      rsp_type r;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $display("%0t unexpected result: read_data %0h changed_flag %0b status %0d",
                     $time, rsp_read_data, rsp_changed_flag, rsp_status);
            error_count++;
         end else begin
            r = expected_results.pop_front();
            results_checked++;
            if (rsp_status == STAT_LOCKED)
               refused_count++;
            if (rsp_status == STAT_RANGE)
               range_count++;
            if (rsp_read_data !== r.read_data) begin
               $display("%0t read_data mismatch: expected %0h actual %0h",
                        $time, r.read_data, rsp_read_data);
               error_count++;
            end
            if (rsp_changed_flag !== r.changed_flag) begin
               $display("%0t changed_flag mismatch: expected %0b actual %0b",
                        $time, r.changed_flag, rsp_changed_flag);
               error_count++;
            end
            if (rsp_status !== r.status) begin
               $display("%0t status mismatch: expected %0d actual %0d",
                        $time, r.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   initial begin
      logic [7:0] user_keys [PHASE_COUNT];
      logic [7:0] master_keys [PHASE_COUNT];
      int settle;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         entry_value[i] = '0;
         entry_class[i] = CLASS_OPEN;
         entry_changed[i] = 1'b0;
      end
      user_keys = '{8'h00, 8'hFF, 8'h3C, 8'($urandom_range(255)), 8'hFF, 8'($urandom_range(255))};
      master_keys = '{8'hFF, 8'h00, 8'hC3, 8'($urandom_range(255)), 8'hFF, 8'($urandom_range(255))};
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      write_key(CSR_USER_KEY, 8'h3C);
      write_key(CSR_MASTER_KEY, 8'hC3);
      idle_pct = 16;

      pending_words.push_back(make_word(ACT_READ, 8'd0, 8'h00, CLASS_OPEN));
      pending_words.push_back(make_word(ACT_WRITE, 8'd0, 8'hFF, CLASS_OPEN));
      pending_words.push_back(make_word(ACT_INCREMENT, 8'd0, 8'h00, CLASS_OPEN));
      pending_words.push_back(make_word(ACT_GET_FLAG, 8'd0, 8'h00, CLASS_OPEN));
      pending_words.push_back(make_word(ACT_CLR_FLAG, 8'd0, 8'h00, CLASS_OPEN));
      pending_words.push_back(make_word(ACT_GET_FLAG, 8'd0, 8'h00, CLASS_OPEN));
      pending_words.push_back(make_word(ACT_RAW_WRITE, 8'd1, 8'h80, CLASS_OPEN));
      pending_words.push_back(make_word(ACT_GET_FLAG, 8'd1, 8'h00, CLASS_OPEN));
      pending_words.push_back(make_word(ACT_SET_CLASS, 8'd2, 8'h00, CLASS_USER));
      pending_words.push_back(make_word(ACT_WRITE, 8'd2, 8'h11, CLASS_OPEN));
      pending_words.push_back(make_word(ACT_SET_CLASS, 8'd3, 8'h00, CLASS_MASTER));
      pending_words.push_back(make_word(ACT_SET_CLASS, 8'd4, 8'hFF, CLASS_SPARE));
      pending_words.push_back(make_word(ACT_RAW_WRITE, 8'(USER_LOCK_INDEX), 8'h3C, CLASS_OPEN));
      pending_words.push_back(make_word(ACT_WRITE, 8'd2, 8'h22, CLASS_SPARE));
      pending_words.push_back(make_word(ACT_WRITE, 8'd3, 8'h33, CLASS_OPEN));
      pending_words.push_back(make_word(ACT_INCREMENT, 8'd4, 8'h00, CLASS_OPEN));
      pending_words.push_back(make_word(ACT_RAW_WRITE, 8'(MASTER_LOCK_INDEX), 8'hC3,
                                        CLASS_OPEN));
      pending_words.push_back(make_word(ACT_INCREMENT, 8'd3, 8'h00, CLASS_OPEN));
      pending_words.push_back(make_word(ACT_WRITE, 8'd4, 8'h44, CLASS_OPEN));
      pending_words.push_back(make_word(ACT_READ, 8'd128, 8'h00, CLASS_OPEN));
      pending_words.push_back(make_word(ACT_WRITE, 8'd255, 8'hFF, CLASS_SPARE));
      pending_words.push_back(make_word(ACT_UNUSED, 8'd5, 8'hFF, CLASS_SPARE));
      pending_words.push_back(make_word(ACT_READ, 8'(RANGE_COUNT_INDEX), 8'h00, CLASS_OPEN));
      pending_words.push_back(make_word(ACT_READ, 8'(LOCKED_COUNT_INDEX), 8'h00, CLASS_OPEN));
      pending_words.push_back(make_word(ACT_GET_FLAG, 8'(LOCKED_COUNT_INDEX), 8'h00,
                                        CLASS_OPEN));

      for (int p = 0; p < PHASE_COUNT; p++) begin
         // hold off until the pipe is empty before touching the keys
         wait_idle();
         write_key(CSR_USER_KEY, user_keys[p]);
         write_key(CSR_MASTER_KEY, master_keys[p]);
         idle_pct = (p < 2) ? 16 : (p < 4) ? 85 : 0;
         for (int i = 0; i < WORDS_PER_PHASE; i++)
            pending_words.push_back(random_word());
      end

      wait_idle();
      settle = 0;
      while (expected_results.size() != 0 && settle < 100) begin
         @(posedge clock);
         settle++;
      end
      $display("sent %0d words over %0d key settings, checked %0d results",
               words_sent, PHASE_COUNT + 1, results_checked);
      $display("refused by lock: %0d, out of range: %0d, mismatches: %0d",
               refused_count, range_count, error_count);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
